// ----- design/pwr_pkg.sv -----
package pwr_pkg;

  // Sizing of the weight store and of the arithmetic.
  localparam int MAX_PARTICLES = 256;
  localparam int WEIGHT_BITS   = 16;

  localparam int IDX_W  = $clog2(MAX_PARTICLES);
  localparam int POS_W  = IDX_W + 1;
  localparam int TOT_W  = WEIGHT_BITS + IDX_W;
  localparam int U_W    = 16;
  localparam int PROD_W = U_W + TOT_W;
  localparam int KEY_W  = TOT_W + 1;

  // Fixed port widths.
  localparam int CFG_W     = 9;
  localparam int IN_W      = 16;
  localparam int OUT_IDX_W = 8;

  localparam logic [CFG_W-1:0] COUNT_RESET = CFG_W'(256);

  // Operation codes carried in op.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_DRAW = 1'b1;

  // Result status codes.
  localparam logic STATUS_OK         = 1'b0;
  localparam logic STATUS_INCOMPLETE = 1'b1;

endpackage

// ----- design/particle_weight_resampler.sv -----
// Particle resampling engine: multinomial draws by inverse cumulative weight.
// Input channel (in_valid_i / in_stall_o) carries beats with op_i, weight_i
// and uniform_draw_i. A load beat (op_i = 0) stores the running prefix sum for
// the next particle and adds its weight to the total; it makes no result and
// the block can take another beat in the very next cycle. A draw beat
// (op_i = 1) returns one result beat on the output channel (out_valid_o /
// out_stall_i) with chosen_index_o and status_o.
// A draw on a complete set passes through MUL (one multiplier pass), THR
// and KEY (forming the search key), then, for more than one particle, SRCH,
// one binary search step per cycle against the single read port of the
// prefix-sum memory, and DONE, which loads the output register before the
// block returns to IDLE and takes its next beat. A draw on an incomplete set
// goes from IDLE straight to DONE with a status-1 result.
// The output register parts both sides: while the receiver stalls, a result
// beat holds steady; a finished search waits in the DONE state until the
// output register is free, and the input stalls meanwhile, as beats are
// taken only in IDLE. Reset clears the load position, the total, the
// set-complete flag and sets particle_count to 256; the prefix-sum memory
// needs no clearing since a draw only ever reads entries of a fully loaded
// set. Writing particle_count restarts loading of the set.
module particle_weight_resampler (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pwr_pkg::CFG_W-1:0]      cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           op_i,
  input  logic [pwr_pkg::IN_W-1:0]       weight_i,
  input  logic [pwr_pkg::U_W-1:0]        uniform_draw_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [pwr_pkg::OUT_IDX_W-1:0]  chosen_index_o,
  output logic                           status_o
);
  import pwr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_THR,
    S_KEY,
    S_SRCH,
    S_DONE
  } state_e;

  localparam logic [TOT_W-1:0] WMASK = TOT_W'((64'd1 << WEIGHT_BITS) - 64'd1);

  state_e                state_q, state_d;
  logic [CFG_W-1:0]      count_q, count_d;
  logic [POS_W-1:0]      load_pos_q, load_pos_d;
  logic [TOT_W-1:0]      total_q, total_d;
  logic                  complete_q, complete_d;
  logic [U_W-1:0]        u_q, u_d;
  logic [PROD_W-1:0]     prod_q, prod_d;
  logic [PROD_W-1:0]     thr_q, thr_d;
  logic [KEY_W-1:0]      key_q, key_d;
  logic [IDX_W-1:0]      lo_q, lo_d;
  logic [IDX_W-1:0]      hi_q, hi_d;
  logic [IDX_W-1:0]      mid_q, mid_d;
  logic [IDX_W-1:0]      res_idx_q, res_idx_d;
  logic                  res_status_q, res_status_d;
  logic                  out_valid_q, out_valid_d;
  logic [OUT_IDX_W-1:0]  out_idx_q, out_idx_d;
  logic                  out_status_q, out_status_d;

  logic [TOT_W-1:0]      mem [MAX_PARTICLES];
  logic [TOT_W-1:0]      rd_q;
  logic                  mem_we;
  logic [IDX_W-1:0]      wr_addr;
  logic [IDX_W-1:0]      rd_addr;

  logic [POS_W-1:0]      eff_n;
  logic [POS_W-1:0]      pos_start;
  logic [POS_W-1:0]      pos_next;
  logic [TOT_W-1:0]      base;
  logic [TOT_W-1:0]      w_ext;
  logic                  in_acc;
  logic                  out_free;
  logic                  qual;
  logic [IDX_W-1:0]      lo_n, hi_n, hi_init;
  logic [IDX_W-1:0]      span_lo, span_hi;
  logic [POS_W-1:0]      span;
  logic [IDX_W-1:0]      mid_calc;

  // A count of zero acts as one particle, a count above the store as the store.
  always_comb begin
    if (count_q == '0) begin
      eff_n = POS_W'(1);
    end else if (32'(count_q) > MAX_PARTICLES) begin
      eff_n = POS_W'(MAX_PARTICLES);
    end else begin
      eff_n = POS_W'(count_q);
    end
  end

  assign in_acc    = in_valid_i && (state_q == S_IDLE);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign pos_start = (load_pos_q >= eff_n) ? '0 : load_pos_q;
  assign pos_next  = pos_start + POS_W'(1);
  assign base      = (pos_start == '0) ? '0 : total_q;
  assign w_ext     = TOT_W'(weight_i) & WMASK;

  // One search step: an index qualifies when its prefix sum, scaled by 2^16,
  // stays below total * (1 - u). The key is that bound rounded up.
  assign qual    = {1'b0, rd_q} < key_q;
  assign lo_n    = qual ? mid_q : lo_q;
  assign hi_n    = qual ? hi_q : mid_q - IDX_W'(1);
  assign hi_init = IDX_W'(eff_n - POS_W'(1));

  assign span_lo  = (state_q == S_SRCH) ? lo_n : '0;
  assign span_hi  = (state_q == S_SRCH) ? hi_n : hi_init;
  assign span     = {1'b0, span_hi} - {1'b0, span_lo} + POS_W'(1);
  assign mid_calc = span_lo + IDX_W'(span >> 1);
  assign rd_addr  = mid_calc;
  assign wr_addr  = pos_start[IDX_W-1:0];

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    load_pos_d   = load_pos_q;
    total_d      = total_q;
    complete_d   = complete_q;
    u_d          = u_q;
    prod_d       = prod_q;
    thr_d        = thr_q;
    key_d        = key_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    mid_d        = mid_q;
    res_idx_d    = res_idx_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q;
    out_idx_d    = out_idx_q;
    out_status_d = out_status_q;
    mem_we       = 1'b0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (op_i == OP_LOAD) begin
            mem_we  = 1'b1;
            total_d = base + w_ext;
            if (pos_next >= eff_n) begin
              load_pos_d = '0;
              complete_d = 1'b1;
            end else begin
              load_pos_d = pos_next;
              complete_d = (pos_start == '0) ? 1'b0 : complete_q;
            end
          end else if (!complete_q) begin
            res_idx_d    = '0;
            res_status_d = STATUS_INCOMPLETE;
            state_d      = S_DONE;
          end else begin
            u_d     = uniform_draw_i;
            state_d = S_MUL;
          end
        end
      end
      S_MUL: begin
        prod_d  = PROD_W'(u_q) * PROD_W'(total_q);
        state_d = S_THR;
      end
      S_THR: begin
        thr_d   = {total_q, U_W'(0)} - prod_q;
        state_d = S_KEY;
      end
      S_KEY: begin
        key_d = KEY_W'(thr_q[PROD_W-1:U_W]) + KEY_W'(thr_q[U_W-1:0] != '0);
        lo_d  = '0;
        hi_d  = hi_init;
        mid_d = mid_calc;
        if (hi_init == '0) begin
          res_idx_d    = '0;
          res_status_d = STATUS_OK;
          state_d      = S_DONE;
        end else begin
          state_d = S_SRCH;
        end
      end
      S_SRCH: begin
        lo_d = lo_n;
        hi_d = hi_n;
        if (lo_n < hi_n) begin
          mid_d = mid_calc;
        end else begin
          res_idx_d    = lo_n;
          res_status_d = STATUS_OK;
          state_d      = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_idx_d    = OUT_IDX_W'(res_idx_q);
          out_status_d = res_status_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // A register write restarts loading of the set.
    if (cfg_we_i) begin
      count_d    = cfg_wdata_i;
      load_pos_d = '0;
      complete_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= COUNT_RESET;
      load_pos_q   <= '0;
      total_q      <= '0;
      complete_q   <= 1'b0;
      u_q          <= '0;
      prod_q       <= '0;
      thr_q        <= '0;
      key_q        <= '0;
      lo_q         <= '0;
      hi_q         <= '0;
      mid_q        <= '0;
      res_idx_q    <= '0;
      res_status_q <= STATUS_OK;
      out_valid_q  <= 1'b0;
      out_idx_q    <= '0;
      out_status_q <= STATUS_OK;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      load_pos_q   <= load_pos_d;
      total_q      <= total_d;
      complete_q   <= complete_d;
      u_q          <= u_d;
      prod_q       <= prod_d;
      thr_q        <= thr_d;
      key_q        <= key_d;
      lo_q         <= lo_d;
      hi_q         <= hi_d;
      mid_q        <= mid_d;
      res_idx_q    <= res_idx_d;
      res_status_q <= res_status_d;
      out_valid_q  <= out_valid_d;
      out_idx_q    <= out_idx_d;
      out_status_q <= out_status_d;
    end
  end

  // Prefix-sum store: one write port for loads, one registered read port
  // for the search.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= base;
    end
    rd_q <= mem[rd_addr];
  end

  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign chosen_index_o = out_idx_q;
  assign status_o       = out_status_q;

`ifndef SYNTHESIS
  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_pos_q < eff_n)
    else $error("load position beyond particle count");

  a_search_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SRCH |-> lo_q < hi_q && mid_q > lo_q && mid_q <= hi_q)
    else $error("search window collapsed while searching");

  a_search_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SRCH |-> POS_W'(hi_q) < eff_n)
    else $error("search bound beyond loaded set");

  a_incomplete_draw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && op_i == OP_DRAW && !complete_q
    |=> state_q == S_DONE && res_status_q == STATUS_INCOMPLETE)
    else $error("draw on incomplete set not flagged");

  a_done_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DONE && !out_valid_q |=> out_valid_q && state_q == S_IDLE)
    else $error("finished result not handed to output register");
`endif

endmodule

// ----- tb/particle_weight_resampler_tb.sv -----
`timescale 1ns / 1ps

// Self-checking bench for the particle resampler. Weight sets are loaded
// beat by beat, draws are issued against them, and every result beat is
// compared with the index that the bench's own inverse-CDF search finds over
// its private copy of the prefix sums. Both channels idle at random.
module particle_weight_resampler_tb;
  import pwr_pkg::*;

  // Run limits. DRAIN_CYCLES covers the tail of a draw on a full set with margin.
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int RANDOM_BEATS = 800;
  localparam int MAX_REPORTS  = 10;

  // Shapes of the weights within one random set.
  typedef enum int {
    W_ANY,
    W_TINY,
    W_SPARSE,
    W_FULL,
    W_NONE
  } weight_shape_e;

  typedef struct packed {
    logic [OUT_IDX_W-1:0] index;
    logic                 status;
  } pick_t;

  logic                 clk_i          = 1'b0;
  logic                 rst_ni         = 1'b0;
  logic                 cfg_we_i       = 1'b0;
  logic [CFG_W-1:0]     cfg_wdata_i    = '0;
  logic                 in_valid_i     = 1'b0;
  logic                 in_stall_o;
  logic                 op_i           = OP_LOAD;
  logic [IN_W-1:0]      weight_i       = '0;
  logic [U_W-1:0]       uniform_draw_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i    = 1'b0;
  logic [OUT_IDX_W-1:0] chosen_index_o;
  logic                 status_o;

  particle_weight_resampler DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .op_i          (op_i),
    .weight_i      (weight_i),
    .uniform_draw_i(uniform_draw_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .chosen_index_o(chosen_index_o),
    .status_o      (status_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Shadow copy of the block's state: the prefix sum stored for each
  // particle, the load position, the running total and the set-complete flag.
  logic [TOT_W-1:0] sums_before [MAX_PARTICLES];
  logic [TOT_W-1:0] running_total = '0;
  int unsigned      fill_pos      = 0;
  bit               set_ready     = 1'b0;
  logic [CFG_W-1:0] count_reg     = COUNT_RESET;

  // Expected draw results, oldest first.
  pick_t expected_picks [$];

  int  fail_count    = 0;
  int  beats_sent    = 0;
  int  loads_sent    = 0;
  int  draws_sent    = 0;
  int  results_seen  = 0;
  int  cfg_writes    = 0;
  bit  gaps_on       = 1'b0;
  bit  in_valid_kept = 1'b0;
  int  stall_left    = 0;
  bit  stall_on      = 1'b0;

  // A count of zero behaves as one particle and counts above the store size
  // behave as a full store.
  function automatic int unsigned active_count();
    if (count_reg == 0) return 1;
    if (count_reg > MAX_PARTICLES) return MAX_PARTICLES;
    return 32'(count_reg);
  endfunction

  // The first load after completion, reset or a count write opens a new set.
  function automatic void absorb_weight(logic [IN_W-1:0] w);
    int unsigned n;
    n = active_count();
    if (fill_pos >= n) fill_pos = 0;
    if (fill_pos == 0) begin
      running_total = '0;
      set_ready     = 1'b0;
    end
    sums_before[IDX_W'(fill_pos)] = running_total;
    running_total += TOT_W'(w[WEIGHT_BITS-1:0]);
    fill_pos++;
    if (fill_pos >= n) begin
      fill_pos  = 0;
      set_ready = 1'b1;
    end
  endfunction

  // Largest particle whose remaining weight (total minus the weights before
  // it), scaled by 2^16, exceeds u times the total. Remaining weight can only
  // shrink with the index, so scanning down from the top finds it. No
  // qualifying particle, a zero total among them, gives index 0.
  function automatic logic [OUT_IDX_W-1:0] pick_particle(logic [U_W-1:0] u);
    longint unsigned target;
    longint unsigned tail;
    int              j;
    target = longint'(u) * longint'(running_total);
    for (j = int'(active_count()) - 1; j >= 0; j--) begin
      tail = longint'(running_total) - longint'(sums_before[IDX_W'(j)]);
      if ((tail << 16) > target) return OUT_IDX_W'(j);
    end
    return '0;
  endfunction

  // Queues one expected result behind those already pending.
  function automatic void note_pick(pick_t p);
    expected_picks = {expected_picks, p};
  endfunction

  // Mostly short pauses, now and then a long one.
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  function automatic logic [IN_W-1:0] weight_for(weight_shape_e shape);
    case (shape)
      W_ANY:    return IN_W'($urandom);
      W_TINY:   return IN_W'($urandom_range(0, 15));
      W_SPARSE: return ($urandom_range(0, 4) == 0) ? IN_W'($urandom) : '0;
      W_FULL:   return '1;
      default:  return '0;
    endcase
  endfunction

  function automatic void report_failure(string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("mismatch: %s", msg);
  endfunction

  // Presents one beat and holds it until the block takes it. Valid stays high
  // when the next beat follows at once, so it is never lowered and raised in
  // the same step.
  task automatic send_beat(logic op, logic [IN_W-1:0] w, logic [U_W-1:0] u);
    int gap;
    op_i           <= op;
    weight_i       <= w;
    uniform_draw_i <= u;
    in_valid_i     <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    beats_sent++;
    if (op == OP_LOAD) begin
      loads_sent++;
      absorb_weight(w);
    end else begin
      draws_sent++;
      if (!set_ready) note_pick(pick_t'{'0, STATUS_INCOMPLETE});
      else note_pick(pick_t'{pick_particle(u), STATUS_OK});
    end
    gap = gaps_on ? idle_length() : 0;
    if (gap > 0) begin
      in_valid_i    <= 1'b0;
      in_valid_kept  = 1'b0;
      repeat (gap) @(posedge clk_i);
    end else begin
      in_valid_kept = 1'b1;
    end
  endtask

  task automatic load_weight(logic [IN_W-1:0] w);
    send_beat(OP_LOAD, w, U_W'($urandom));
  endtask

  task automatic draw(logic [U_W-1:0] u);
    send_beat(OP_DRAW, IN_W'($urandom), u);
  endtask

  task automatic stop_input();
    if (in_valid_kept) begin
      in_valid_i    <= 1'b0;
      in_valid_kept  = 1'b0;
    end
  endtask

  // Waits until every draw has answered and any trailing load has finished.
  task automatic settle();
    while (expected_picks.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Writing the count restarts loading; the stale total is dropped by the
  // next load.
  task automatic write_count(logic [CFG_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    count_reg = value;
    fill_pos  = 0;
    set_ready = 1'b0;
    cfg_writes++;
  endtask

  // Result side: check each accepted beat against the oldest expectation,
  // then decide the stall for the next cycle. Stall runs and free runs
  // follow at random, so some stretches see no back-pressure at all.
  task automatic take_result();
    pick_t want;
    results_seen++;
    if (expected_picks.size() == 0) begin
      report_failure($sformatf("result beat with nothing pending: index %0d status %0d",
                               chosen_index_o, status_o));
      return;
    end
    want = expected_picks.pop_front();
    if (chosen_index_o !== want.index || status_o !== want.status)
      report_failure($sformatf("index %0d status %0d, expected index %0d status %0d",
                               chosen_index_o, status_o, want.index, want.status));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) take_result();
    if (stall_left == 0) begin
      stall_on   = ($urandom_range(0, 2) == 0);
      stall_left = stall_on ? 1 + idle_length() : $urandom_range(1, 40);
    end
    stall_left--;
    out_stall_i <= stall_on;
  end

  // Draws right after reset: the default count is 256 and nothing is loaded,
  // so every draw reports an incomplete set, even after one load.
  task automatic run_draws_before_load();
    gaps_on = 1'b0;
    draw('0);
    draw('1);
    load_weight(16'h1234);
    draw(16'h8000);
    stop_input();
  endtask

  // One particle: any draw must return it, and a set with a zero total
  // returns index 0 with a good status.
  task automatic run_single_particle();
    settle();
    write_count(CFG_W'(1));
    gaps_on = 1'b1;
    load_weight('1);
    draw('0);
    draw('1);
    load_weight('0);
    draw(16'h8000);
    stop_input();
  endtask

  // Out-of-range counts: zero acts as one, anything above the store size as
  // the full store, so a single load does not complete the set there.
  task automatic run_count_limits();
    settle();
    write_count('0);
    load_weight(16'h00ff);
    draw('0);
    stop_input();
    settle();
    write_count('1);
    load_weight(16'h0005);
    draw('1);
    stop_input();
    settle();
    write_count(CFG_W'(MAX_PARTICLES + 1));
    draw(16'h0001);
    stop_input();
  endtask

  // A small set with zero and full-scale weights, a draw in the middle of
  // loading, draws at both ends of the range, and a reload that makes the
  // set incomplete again.
  task automatic run_small_set();
    settle();
    write_count(CFG_W'(4));
    load_weight(16'h0001);
    load_weight('0);
    load_weight('1);
    draw(16'h4000);
    load_weight('0);
    draw('0);
    draw('1);
    draw(16'h8000);
    draw(16'h0001);
    load_weight(16'h0007);
    draw(16'hc000);
    stop_input();
  endtask

  // Random sets: mostly a full set of weights of one shape followed by a run
  // of draws, with stray draws during loading and some sets cut short. Most
  // counts are small so that many sets fit; a few fill the whole store.
  task automatic run_random_sets();
    int            start_beats;
    int            r;
    int unsigned   n;
    int unsigned   loads;
    int            draws;
    int            i;
    weight_shape_e shape;
    logic [U_W-1:0] u;
    start_beats = beats_sent;
    while (beats_sent - start_beats < RANDOM_BEATS) begin
      if ($urandom_range(0, 2) != 0) begin
        stop_input();
        settle();
        r = $urandom_range(0, 99);
        if (r < 60)      write_count(CFG_W'($urandom_range(1, 16)));
        else if (r < 80) write_count(CFG_W'($urandom_range(17, 64)));
        else if (r < 90) write_count(CFG_W'($urandom_range(65, MAX_PARTICLES - 1)));
        else if (r < 95) write_count(CFG_W'(MAX_PARTICLES));
        else if (r < 97) write_count('0);
        else             write_count(CFG_W'($urandom_range(MAX_PARTICLES + 1, 511)));
      end
      gaps_on = ($urandom_range(0, 3) != 0);
      shape   = weight_shape_e'($urandom_range(0, 4));
      n       = active_count();
      loads   = ($urandom_range(0, 5) == 0) ? $urandom_range(0, n - 1) : n;
      for (i = 0; i < loads; i++) begin
        if ($urandom_range(0, 11) == 0) draw(U_W'($urandom));
        load_weight(weight_for(shape));
      end
      draws = $urandom_range(3, 16);
      for (i = 0; i < draws; i++) begin
        r = $urandom_range(0, 9);
        if (r == 0)      u = '0;
        else if (r == 1) u = '1;
        else             u = U_W'($urandom);
        draw(u);
      end
    end
    stop_input();
  endtask

  // Watchdog: a hung handshake or a missing result ends the run here.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_draws_before_load();
    run_single_particle();
    run_count_limits();
    run_small_set();
    run_random_sets();

    settle();
    $display("Sent %0d beats (%0d loads, %0d draws) over %0d count settings;",
             beats_sent, loads_sent, draws_sent, cfg_writes);
    $display("checked %0d result beats, %0d failures.", results_seen, fail_count);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- particle_weight_resampler.f -----
design/pwr_pkg.sv
design/particle_weight_resampler.sv
tb/particle_weight_resampler_tb.sv
